### src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, ignored while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

### src/bglu_pkg.sv
// Shared types and constants of the binary GCD/LCM unit.
`default_nettype none

package bglu_pkg;

  localparam int DATA_WIDTH_DEFAULT = 32;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_CHECK  = 9'b000000010,
    ST_STRIP2 = 9'b000000100,
    ST_STRIPX = 9'b000001000,
    ST_STRIPY = 9'b000010000,
    ST_SUB    = 9'b000100000,
    ST_DIV    = 9'b001000000,
    ST_MUL    = 9'b010000000,
    ST_DONE   = 9'b100000000
  } state_t;

  typedef struct packed {
    logic load;
    logic zero_out;
    logic strip_both;
    logic strip_x;
    logic strip_y;
    logic sub;
    logic div_init;
    logic div_step;
    logic mul;
  } cmd_t;

  typedef struct packed {
    logic any_zero;
    logic both_even;
    logic x_even;
    logic y_even;
    logic x_eq_y;
    logic div_last;
  } status_t;

endpackage

`default_nettype wire

### src/bglu_ctrl.sv
// Controller state machine of the binary GCD/LCM unit.
`default_nettype none

module bglu_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire bglu_pkg::status_t status,
  output bglu_pkg::cmd_t        cmd,
  output logic                  busy,
  output logic                  done
);

  bglu_pkg::state_t state;
  bglu_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bglu_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      bglu_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = bglu_pkg::ST_CHECK;
        end
      end
      bglu_pkg::ST_CHECK: begin
        if (status.any_zero) begin
          cmd.zero_out = 1'b1;
          state_next   = bglu_pkg::ST_DONE;
        end else begin
          state_next = bglu_pkg::ST_STRIP2;
        end
      end
      bglu_pkg::ST_STRIP2: begin
        if (status.both_even) begin
          cmd.strip_both = 1'b1;
        end else begin
          state_next = bglu_pkg::ST_STRIPX;
        end
      end
      bglu_pkg::ST_STRIPX: begin
        if (status.x_even) begin
          cmd.strip_x = 1'b1;
        end else begin
          state_next = bglu_pkg::ST_STRIPY;
        end
      end
      bglu_pkg::ST_STRIPY: begin
        if (status.y_even) begin
          cmd.strip_y = 1'b1;
        end else begin
          state_next = bglu_pkg::ST_SUB;
        end
      end
      bglu_pkg::ST_SUB: begin
        if (status.x_eq_y) begin
          cmd.div_init = 1'b1;
          state_next   = bglu_pkg::ST_DIV;
        end else begin
          cmd.sub    = 1'b1;
          state_next = bglu_pkg::ST_STRIPY;
        end
      end
      bglu_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = bglu_pkg::ST_MUL;
        end
      end
      bglu_pkg::ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = bglu_pkg::ST_DONE;
      end
      bglu_pkg::ST_DONE: begin
        state_next = bglu_pkg::ST_IDLE;
      end
      default: begin
        state_next = bglu_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state != bglu_pkg::ST_IDLE);
  assign done = (state == bglu_pkg::ST_DONE);

endmodule

`default_nettype wire

### src/bglu_dp.sv
// Datapath of the binary GCD/LCM unit: magnitudes, Stein loop, divider, multiplier.
`default_nettype none

module bglu_dp #(
  parameter int DATA_WIDTH = bglu_pkg::DATA_WIDTH_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic [DATA_WIDTH-1:0] operand_a,
  input  wire logic [DATA_WIDTH-1:0] operand_b,
  input  wire bglu_pkg::cmd_t        cmd,
  output bglu_pkg::status_t          status,
  output logic [DATA_WIDTH-1:0]      gcd_magnitude,
  output logic [DATA_WIDTH-1:0]      lcm_low_bits,
  output logic                       lcm_overflow
);

  localparam int W  = DATA_WIDTH;
  localparam int TW = $clog2(DATA_WIDTH);

  logic [W-1:0]   mag_a;
  logic [W-1:0]   mag_b;
  logic [W-1:0]   ma;
  logic [W-1:0]   mb;
  logic [W-1:0]   x;
  logic [W-1:0]   y;
  logic [TW-1:0]  twos;
  logic [W-1:0]   divisor;
  logic [W-1:0]   rem;
  logic [W-1:0]   quo;
  logic [TW-1:0]  cnt;
  logic [W:0]     rem_shift;
  logic [W:0]     rem_diff;
  logic [2*W-1:0] prod;

  assign mag_a = operand_a[W-1] ? (~operand_a + 1'b1) : operand_a;
  assign mag_b = operand_b[W-1] ? (~operand_b + 1'b1) : operand_b;

  assign rem_shift = {rem, quo[W-1]};
  assign rem_diff  = rem_shift - {1'b0, divisor};
  assign prod      = {{W{1'b0}}, quo} * {{W{1'b0}}, mb};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ma   <= mag_a;
      mb   <= mag_b;
      x    <= mag_a;
      y    <= mag_b;
      twos <= '0;
    end
    if (cmd.zero_out) begin
      gcd_magnitude <= ma | mb;
      lcm_low_bits  <= '0;
      lcm_overflow  <= 1'b0;
    end
    if (cmd.strip_both) begin
      x    <= x >> 1;
      y    <= y >> 1;
      twos <= twos + 1'b1;
    end
    if (cmd.strip_x) begin
      x <= x >> 1;
    end
    if (cmd.strip_y) begin
      y <= y >> 1;
    end
    if (cmd.sub) begin
      if (x > y) begin
        x <= y;
        y <= x - y;
      end else begin
        y <= y - x;
      end
    end
    if (cmd.div_init) begin
      divisor       <= x << twos;
      gcd_magnitude <= x << twos;
      rem           <= '0;
      quo           <= ma;
      cnt           <= '0;
    end
    if (cmd.div_step) begin
      if (!rem_diff[W]) begin
        rem <= rem_diff[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= rem_shift[W-1:0];
        quo <= {quo[W-2:0], 1'b0};
      end
      cnt <= cnt + 1'b1;
    end
    if (cmd.mul) begin
      lcm_low_bits <= prod[W-1:0];
      lcm_overflow <= |prod[2*W-1:W-1];
    end
  end

  assign status.any_zero  = (ma == '0) || (mb == '0);
  assign status.both_even = !x[0] && !y[0];
  assign status.x_even    = !x[0];
  assign status.y_even    = !y[0];
  assign status.x_eq_y    = (x == y);
  assign status.div_last  = (cnt == TW'(W - 1));

endmodule

`default_nettype wire

### src/binary_gcd_lcm_unit_core.sv
// Top level of the binary GCD/LCM unit.
//
// Usage: present operand_a and operand_b (signed, two's complement) and raise
// start while busy is low; the request is taken at that clock edge. busy stays
// high until the result has been shown. The result appears on gcd_magnitude,
// lcm_low_bits and lcm_overflow for exactly one cycle, marked by done, and the
// receiver must take it then. One request is worked on at a time.
// Sequence: the Stein loop runs its shifts and subtracts, then the restoring
// divider divides |a| by the GCD, then the multiply step forms the LCM and
// the result state shows it. When either operand is zero, the controller
// goes from its check state straight to the result state.
// A new request can be taken in the cycle after done.
// Reset (rst, synchronous) returns the controller to idle; any request in
// flight is dropped.
`default_nettype none

module binary_gcd_lcm_unit_core #(
  parameter int DATA_WIDTH = bglu_pkg::DATA_WIDTH_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic signed [DATA_WIDTH-1:0] operand_a,
  input  wire logic signed [DATA_WIDTH-1:0] operand_b,
  output logic                              done,
  output logic [DATA_WIDTH-1:0]             gcd_magnitude,
  output logic signed [DATA_WIDTH-1:0]      lcm_low_bits,
  output logic                              lcm_overflow
);

  bglu_pkg::cmd_t    cmd;
  bglu_pkg::status_t status;
  logic [DATA_WIDTH-1:0] lcm_bits;

  bglu_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  bglu_dp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk           (clk),
    .operand_a     ($unsigned(operand_a)),
    .operand_b     ($unsigned(operand_b)),
    .cmd           (cmd),
    .status        (status),
    .gcd_magnitude (gcd_magnitude),
    .lcm_low_bits  (lcm_bits),
    .lcm_overflow  (lcm_overflow)
  );

  assign lcm_low_bits = $signed(lcm_bits);

endmodule

`default_nettype wire

### src/bglu_chk.sv
// Port-level checker of the binary GCD/LCM unit and its bind.
`default_nettype none

`include "assert_macros.svh"

module bglu_chk #(
  parameter int DATA_WIDTH = bglu_pkg::DATA_WIDTH_DEFAULT
) (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  start,
  input wire logic                  busy,
  input wire logic                  done,
  input wire logic [DATA_WIDTH-1:0] gcd_magnitude,
  input wire logic [DATA_WIDTH-1:0] lcm_low_bits,
  input wire logic                  lcm_overflow
);

  logic gcd_zero;
  logic lcm_clear;

  assign gcd_zero  = (gcd_magnitude == '0);
  assign lcm_clear = (lcm_low_bits == '0) && !lcm_overflow;

  `ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !busy && !done)
  `ASSERT_CLK(a_done_while_busy, clk, rst, done |-> busy)
  `ASSERT_CLK(a_request_goes_busy, clk, rst, start && !busy |=> busy && !done)
  `ASSERT_CLK(a_done_single, clk, rst, done |=> !done && !busy)
  `ASSERT_CLK(a_zero_gcd_zero_lcm, clk, rst, done && gcd_zero |-> lcm_clear)

endmodule

bind binary_gcd_lcm_unit_core bglu_chk #(
  .DATA_WIDTH (DATA_WIDTH)
) u_bglu_chk (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .gcd_magnitude (gcd_magnitude),
  .lcm_low_bits  (lcm_low_bits),
  .lcm_overflow  (lcm_overflow)
);

`default_nettype wire

### bench/tb_binary_gcd_lcm_unit_core.sv
// Self-checking testbench for binary_gcd_lcm_unit_core: random and corner operand pairs.
`default_nettype none

module tb_binary_gcd_lcm_unit_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = bglu_pkg::DATA_WIDTH_DEFAULT;
  localparam logic signed [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] MOST_POS = {1'b0, {(W-1){1'b1}}};

  typedef struct {
    logic [W-1:0]        gcd;
    logic signed [W-1:0] lcm;
    logic                ovf;
  } gcd_lcm_t;

  class gcd_lcm_scoreboard;
    gcd_lcm_t pending_gcd_lcm[$];
    int       errors = 0;

    function gcd_lcm_t predict_gcd_lcm(logic signed [W-1:0] a, logic signed [W-1:0] b);
      logic [63:0] ma;
      logic [63:0] mb;
      logic [63:0] x;
      logic [63:0] y;
      logic [63:0] t;
      logic [63:0] prod;
      gcd_lcm_t    r;
      ma = {32'd0, (a[W-1] ? -a : a)};
      mb = {32'd0, (b[W-1] ? -b : b)};
      x = ma;
      y = mb;
      while (y != 0) begin
        t = x % y;
        x = y;
        y = t;
      end
      r.gcd = x[W-1:0];
      r.lcm = '0;
      r.ovf = 1'b0;
      if (ma != 0 && mb != 0) begin
        prod  = (ma / x) * mb;
        r.lcm = prod[W-1:0];
        r.ovf = prod > {32'd0, MOST_POS};
      end
      return r;
    endfunction

    function void note_request(logic signed [W-1:0] a, logic signed [W-1:0] b);
      pending_gcd_lcm.push_back(predict_gcd_lcm(a, b));
    endfunction

    function void check_result(logic [W-1:0] g, logic signed [W-1:0] l, logic o);
      gcd_lcm_t e;
      if (pending_gcd_lcm.size() == 0) begin
        $error("unexpected result: gcd_magnitude %0d lcm_low_bits %0d", g, l);
        errors++;
        return;
      end
      e = pending_gcd_lcm.pop_front();
      if (g !== e.gcd) begin
        $error("gcd_magnitude: expected %0d, actual %0d", e.gcd, g);
        errors++;
      end
      if (l !== e.lcm) begin
        $error("lcm_low_bits: expected %0d, actual %0d", e.lcm, l);
        errors++;
      end
      if (o !== e.ovf) begin
        $error("lcm_overflow: expected %0b, actual %0b", e.ovf, o);
        errors++;
      end
    endfunction

    function int pending();
      return pending_gcd_lcm.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic signed [W-1:0] operand_a = '0;
  logic signed [W-1:0] operand_b = '0;
  logic                busy;
  logic                done;
  logic [W-1:0]        gcd_magnitude;
  logic signed [W-1:0] lcm_low_bits;
  logic                lcm_overflow;

  gcd_lcm_scoreboard sb = new();

  binary_gcd_lcm_unit_core #(.DATA_WIDTH(W)) u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operand_a    (operand_a),
    .operand_b    (operand_b),
    .done         (done),
    .gcd_magnitude(gcd_magnitude),
    .lcm_low_bits (lcm_low_bits),
    .lcm_overflow (lcm_overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      sb.check_result(gcd_magnitude, lcm_low_bits, lcm_overflow);
    end
  end

  task automatic send_request(logic signed [W-1:0] a, logic signed [W-1:0] b);
    start     <= 1'b1;
    operand_a <= a;
    operand_b <= b;
    do @(posedge clk); while (busy);
    sb.note_request(a, b);
  endtask

  task automatic drain_requests();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic signed [W-1:0] rand_operand();
    logic signed [W-1:0] v;
    case ($urandom_range(9))
      0, 1, 2: v = $urandom;
      3:       v = $signed($urandom_range(128)) - 64;
      4:       v = '0;
      5: begin
        case ($urandom_range(3))
          0: v = MOST_NEG;
          1: v = MOST_POS;
          2: v = -1;
          default: v = 1;
        endcase
      end
      6:       v = $signed(32'd1 << $urandom_range(W - 1));
      default: v = $signed($urandom_range(65535));
    endcase
    if ($urandom_range(1)) v = -v;
    return v;
  endfunction

  task automatic send_random(int count, int idle_pct);
    logic signed [W-1:0] a;
    logic signed [W-1:0] b;
    logic [W-1:0]        g;
    for (int i = 0; i < count; i++) begin
      while ($urandom_range(99) < idle_pct) begin
        start     <= 1'b0;
        operand_a <= $urandom;
        operand_b <= $urandom;
        @(posedge clk);
      end
      if ($urandom_range(2) == 0) begin
        g = ($urandom_range(4095) | 1) << $urandom_range(12);
        a = g * $urandom_range(1, 4095);
        b = g * $urandom_range(1, 4095);
        if ($urandom_range(1)) a = -a;
        if ($urandom_range(1)) b = -b;
      end else begin
        a = rand_operand();
        b = rand_operand();
      end
      send_request(a, b);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_request(0, 0);
    send_request(0, 5);
    send_request(-7, 0);
    send_request(MOST_NEG, 0);
    send_request(0, MOST_NEG);
    send_request(MOST_NEG, MOST_NEG);
    send_request(MOST_POS, MOST_POS);
    send_request(MOST_POS, MOST_NEG);
    send_request(MOST_NEG, -2);
    send_request(-1, -1);
    send_request(1, MOST_NEG);
    send_request(-1, MOST_POS);
    send_request(12, 18);
    send_request(-12, 18);
    send_request(32'h4000_0000, 32'h0010_0000);
    send_request(MOST_POS, MOST_POS - 1);
    send_request(46341, 46340);
    send_request(32'h0000_FFFF, 32'h0001_0001);
    send_request(65536, 196608);
    send_request(-MOST_POS, 3);
    send_request(3, 5);
    send_request(2147483629, 2147483587);
    send_request(32'h5555_5555, 32'hAAAA_AAAA);
    drain_requests();

    send_random(180, 10);
    drain_requests();
    send_random(180, 64);
    drain_requests();
    send_random(180, 0);
    drain_requests();

    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("FAIL");
    $finish;
  end
endmodule

`default_nettype wire

### sim.f
+incdir+src
src/bglu_pkg.sv
src/bglu_ctrl.sv
src/bglu_dp.sv
src/binary_gcd_lcm_unit_core.sv
src/bglu_chk.sv
bench/tb_binary_gcd_lcm_unit_core.sv
